[sv/ncd_pkg.sv]
// ----------------------------------------------------------------------------
// ncd_pkg
// Shared widths, distance codes and the engine status bundle of the
// negative cycle detector.
// ----------------------------------------------------------------------------
package ncd_pkg;

  localparam int VERTEX_BITS = 10;
  localparam int NV_BITS     = 11;
  localparam int DIST_BITS   = 32;
  localparam int SUM_BITS    = DIST_BITS + 1;

  // largest code is reserved for unreached vertices
  localparam logic [DIST_BITS-1:0] DIST_INF = {1'b0, {(DIST_BITS-1){1'b1}}};
  localparam logic [DIST_BITS-1:0] DIST_TOP = {1'b0, {(DIST_BITS-2){1'b1}}, 1'b0};

  typedef struct packed {
    logic busy;
    logic done;
    logic result;
  } ncd_status_t;

endpackage

[sv/ncd_edge_ram.sv]
// ----------------------------------------------------------------------------
// ncd_edge_ram
// Edge storage: raw arrival region in the lower half, source-sorted copy in
// the upper half. One write port, one registered read port with enable.
// ----------------------------------------------------------------------------
module ncd_edge_ram #(
  parameter int DEPTH = 8192,
  parameter int AW    = 13,
  parameter int DW    = 36
) (
  input  logic          clk,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [DW-1:0] wr_data,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [DW-1:0] rd_data
);

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

[sv/ncd_dist_ram.sv]
// ----------------------------------------------------------------------------
// ncd_dist_ram
// Per-vertex word store: distance table, and group counters while sorting.
// One write port, two registered read ports.
// ----------------------------------------------------------------------------
module ncd_dist_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                         clk,
  input  logic                         wr_en,
  input  logic [AW-1:0]                wr_addr,
  input  logic [ncd_pkg::DIST_BITS-1:0] wr_data,
  input  logic [AW-1:0]                rd_addr_a,
  input  logic [AW-1:0]                rd_addr_b,
  output logic [ncd_pkg::DIST_BITS-1:0] rd_data_a,
  output logic [ncd_pkg::DIST_BITS-1:0] rd_data_b
);

  import ncd_pkg::*;

  logic [DIST_BITS-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_a <= mem[rd_addr_a];
    rd_data_b <= mem[rd_addr_b];
  end

endmodule

[sv/ncd_engine.sv]
// ----------------------------------------------------------------------------
// ncd_engine
// Edge loading and the check sequencer: counting sort of the edges by source,
// distance init, per-root Bellman-Ford passes and the per-vertex edge test.
// ----------------------------------------------------------------------------
module ncd_engine #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  input  logic [ncd_pkg::VERTEX_BITS-1:0]   edge_from,
  input  logic [ncd_pkg::VERTEX_BITS-1:0]   edge_to,
  input  logic signed [15:0]                edge_weight,
  input  logic                              edge_valid,
  input  logic                              last_edge,
  input  logic [ncd_pkg::NV_BITS-1:0]       nv,
  output ncd_pkg::ncd_status_t              status
);

  import ncd_pkg::*;

  localparam int VAW       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int ETW       = $clog2(MAX_EDGES + 1);
  localparam int EAW       = $clog2(2 * MAX_EDGES);
  localparam int EW        = 2 * VERTEX_BITS + WEIGHT_BITS;
  localparam logic [EAW-1:0] SORT_BASE = EAW'(MAX_EDGES);

  typedef enum logic [4:0] {
    S_LOAD, S_CLR,
    S_CNT_E, S_CNT_D, S_CNT_W,
    S_PRE_R, S_PRE_W,
    S_PL_E, S_PL_D, S_PL_W,
    S_INF, S_VIS_R, S_VIS_D,
    S_REL_E, S_REL_D, S_REL_X,
    S_CHK_E, S_CHK_D, S_CHK_X,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic [ETW-1:0]     edge_total, edge_total_next;
  logic [ETW-1:0]     k, k_next;
  logic [ETW-1:0]     count, count_next;
  logic [ETW-1:0]     cp, cp_next;
  logic [ETW-1:0]     sum, sum_next;
  logic [NV_BITS-1:0] i, i_next;
  logic [NV_BITS-1:0] u, u_next;
  logic [NV_BITS-1:0] pass, pass_next;
  logic               result, result_next;

  // ram ports
  logic           e_wr_en, e_rd_en;
  logic [EAW-1:0] e_wr_addr, e_rd_addr;
  logic [EW-1:0]  e_wr_data, e_rd_data;
  logic                 d_wr_en;
  logic [VAW-1:0]       d_wr_addr, d_ra, d_rb;
  logic [DIST_BITS-1:0] d_wr_data, qa, qb;

  // fields of the edge word on the read port
  logic [VERTEX_BITS-1:0] e_from, e_to;
  logic [WEIGHT_BITS-1:0] e_w;
  logic [31:0]            weight_raw;
  logic                   accept, store, in_range;
  logic [NV_BITS-1:0]     nv_last;
  logic signed [SUM_BITS-1:0] sum_rel, qb_ext;
  logic                   under, over, improve, chk_fail;
  logic [DIST_BITS-1:0]   sum_clamp;

  assign e_from = e_rd_data[EW-1 -: VERTEX_BITS];
  assign e_to   = e_rd_data[EW-VERTEX_BITS-1 -: VERTEX_BITS];
  assign e_w    = e_rd_data[WEIGHT_BITS-1:0];

  assign weight_raw = {16'b0, edge_weight};
  assign accept     = start && (state == S_LOAD);
  assign store      = accept && edge_valid && (edge_total < ETW'(MAX_EDGES));
  assign in_range   = ({1'b0, e_from} < nv) && ({1'b0, e_to} < nv);
  assign nv_last    = nv - NV_BITS'(1);

  // saturating relaxation sum
  assign sum_rel   = SUM_BITS'(signed'(qa)) + SUM_BITS'(signed'(e_w));
  assign qb_ext    = SUM_BITS'(signed'(qb));
  assign under     = sum_rel[DIST_BITS] & ~sum_rel[DIST_BITS-1];
  assign over      = ~sum_rel[DIST_BITS] &
                     (sum_rel[DIST_BITS-1] | (&sum_rel[DIST_BITS-2:0]));
  assign sum_clamp = over ? DIST_TOP : sum_rel[DIST_BITS-1:0];
  assign improve   = signed'(qb) > signed'(sum_clamp);
  assign chk_fail  = (qb == DIST_INF) || (qb_ext > sum_rel);

  always_comb begin
    logic adv_u;
    adv_u           = 1'b0;
    state_next      = state;
    edge_total_next = edge_total;
    k_next          = k;
    count_next      = count;
    cp_next         = cp;
    sum_next        = sum;
    i_next          = i;
    u_next          = u;
    pass_next       = pass;
    result_next     = result;
    e_wr_en         = 1'b0;
    e_wr_addr       = EAW'(edge_total);
    e_wr_data       = {edge_from, edge_to, weight_raw[WEIGHT_BITS-1:0]};
    e_rd_en         = 1'b0;
    e_rd_addr       = EAW'(k);
    d_wr_en         = 1'b0;
    d_wr_addr       = VAW'(i);
    d_wr_data       = '0;
    d_ra            = VAW'(i);
    d_rb            = VAW'(e_to);

    unique case (state)
      S_LOAD: begin
        if (accept) begin
          if (store) begin
            e_wr_en         = 1'b1;
            edge_total_next = edge_total + ETW'(1);
          end
          if (last_edge) begin
            i_next = '0;
            if (nv == '0) begin
              result_next = 1'b0;
              state_next  = S_DONE;
            end else begin
              state_next = S_CLR;
            end
          end
        end
      end
      // counters of edges per source
      S_CLR: begin
        d_wr_en = 1'b1;
        if (i == nv_last) begin
          k_next     = '0;
          count_next = '0;
          state_next = S_CNT_E;
        end else begin
          i_next = i + NV_BITS'(1);
        end
      end
      S_CNT_E: begin
        if (k == edge_total) begin
          i_next     = '0;
          sum_next   = '0;
          state_next = S_PRE_R;
        end else begin
          e_rd_en    = 1'b1;
          state_next = S_CNT_D;
        end
      end
      S_CNT_D: begin
        d_ra = VAW'(e_from);
        if (in_range) begin
          state_next = S_CNT_W;
        end else begin
          k_next     = k + ETW'(1);
          state_next = S_CNT_E;
        end
      end
      S_CNT_W: begin
        d_wr_en    = 1'b1;
        d_wr_addr  = VAW'(e_from);
        d_wr_data  = qa + DIST_BITS'(1);
        count_next = count + ETW'(1);
        k_next     = k + ETW'(1);
        state_next = S_CNT_E;
      end
      // exclusive prefix sum gives each source's first sorted slot
      S_PRE_R: begin
        state_next = S_PRE_W;
      end
      S_PRE_W: begin
        d_wr_en   = 1'b1;
        d_wr_data = DIST_BITS'(sum);
        sum_next  = sum + qa[ETW-1:0];
        if (i == nv_last) begin
          k_next     = '0;
          state_next = S_PL_E;
        end else begin
          i_next     = i + NV_BITS'(1);
          state_next = S_PRE_R;
        end
      end
      S_PL_E: begin
        if (k == edge_total) begin
          i_next     = '0;
          state_next = S_INF;
        end else begin
          e_rd_en    = 1'b1;
          state_next = S_PL_D;
        end
      end
      S_PL_D: begin
        d_ra = VAW'(e_from);
        if (in_range) begin
          state_next = S_PL_W;
        end else begin
          k_next     = k + ETW'(1);
          state_next = S_PL_E;
        end
      end
      S_PL_W: begin
        d_wr_en    = 1'b1;
        d_wr_addr  = VAW'(e_from);
        d_wr_data  = qa + DIST_BITS'(1);
        e_wr_en    = 1'b1;
        e_wr_addr  = SORT_BASE + EAW'(qa[ETW-1:0]);
        e_wr_data  = e_rd_data;
        k_next     = k + ETW'(1);
        state_next = S_PL_E;
      end
      S_INF: begin
        d_wr_en   = 1'b1;
        d_wr_data = DIST_INF;
        if (i == nv_last) begin
          u_next     = '0;
          cp_next    = '0;
          state_next = S_VIS_R;
        end else begin
          i_next = i + NV_BITS'(1);
        end
      end
      S_VIS_R: begin
        d_ra       = VAW'(u);
        state_next = S_VIS_D;
      end
      S_VIS_D: begin
        if (qa == DIST_INF) begin
          d_wr_en    = 1'b1;
          d_wr_addr  = VAW'(u);
          d_wr_data  = '0;
          pass_next  = '0;
          k_next     = '0;
          state_next = S_REL_E;
        end else begin
          state_next = S_CHK_E;
        end
      end
      S_REL_E: begin
        if (count == '0) begin
          state_next = S_CHK_E;
        end else begin
          e_rd_en    = 1'b1;
          e_rd_addr  = SORT_BASE;
          state_next = S_REL_D;
        end
      end
      S_REL_D: begin
        d_ra       = VAW'(e_from);
        d_rb       = VAW'(e_to);
        state_next = S_REL_X;
      end
      S_REL_X: begin
        if ((qa != DIST_INF) && under) begin
          result_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          if ((qa != DIST_INF) && improve) begin
            d_wr_en   = 1'b1;
            d_wr_addr = VAW'(e_to);
            d_wr_data = sum_clamp;
          end
          // next edge is fetched while this one is written back
          if (k == count - ETW'(1)) begin
            k_next = '0;
            if (pass == nv_last) begin
              state_next = S_CHK_E;
            end else begin
              pass_next  = pass + NV_BITS'(1);
              e_rd_en    = 1'b1;
              e_rd_addr  = SORT_BASE;
              state_next = S_REL_D;
            end
          end else begin
            k_next     = k + ETW'(1);
            e_rd_en    = 1'b1;
            e_rd_addr  = SORT_BASE + EAW'(k + ETW'(1));
            state_next = S_REL_D;
          end
        end
      end
      // sorted groups come in vertex order, so one pointer walks them
      S_CHK_E: begin
        if (cp == count) begin
          adv_u = 1'b1;
        end else begin
          e_rd_en    = 1'b1;
          e_rd_addr  = SORT_BASE + EAW'(cp);
          state_next = S_CHK_D;
        end
      end
      S_CHK_D: begin
        if ({1'b0, e_from} != u) begin
          adv_u = 1'b1;
        end else begin
          d_ra       = VAW'(u);
          d_rb       = VAW'(e_to);
          state_next = S_CHK_X;
        end
      end
      S_CHK_X: begin
        if (chk_fail) begin
          result_next = 1'b1;
          state_next  = S_DONE;
        end else begin
          cp_next    = cp + ETW'(1);
          state_next = S_CHK_E;
        end
      end
      S_DONE: begin
        edge_total_next = '0;
        state_next      = S_LOAD;
      end
    endcase

    if (adv_u) begin
      if (u == nv_last) begin
        result_next = 1'b0;
        state_next  = S_DONE;
      end else begin
        u_next     = u + NV_BITS'(1);
        state_next = S_VIS_R;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_LOAD;
      edge_total <= '0;
      result     <= 1'b0;
    end else begin
      state      <= state_next;
      edge_total <= edge_total_next;
      result     <= result_next;
    end
    k     <= k_next;
    count <= count_next;
    cp    <= cp_next;
    sum   <= sum_next;
    i     <= i_next;
    u     <= u_next;
    pass  <= pass_next;
  end

  assign status.busy   = (state != S_LOAD);
  assign status.done   = (state == S_DONE);
  assign status.result = result;

  ncd_edge_ram #(
    .DEPTH (2 * MAX_EDGES),
    .AW    (EAW),
    .DW    (EW)
  ) u_edge_ram (
    .clk     (clk),
    .wr_en   (e_wr_en),
    .wr_addr (e_wr_addr),
    .wr_data (e_wr_data),
    .rd_en   (e_rd_en),
    .rd_addr (e_rd_addr),
    .rd_data (e_rd_data)
  );

  ncd_dist_ram #(
    .DEPTH (MAX_VERTICES),
    .AW    (VAW)
  ) u_dist_ram (
    .clk       (clk),
    .wr_en     (d_wr_en),
    .wr_addr   (d_wr_addr),
    .wr_data   (d_wr_data),
    .rd_addr_a (d_ra),
    .rd_addr_b (d_rb),
    .rd_data_a (qa),
    .rd_data_b (qb)
  );

endmodule

[sv/negative_cycle_detector.sv]
// ----------------------------------------------------------------------------
// negative_cycle_detector
// Collects the weighted edges of one graph and reports whether it contains a
// negative cycle (Bellman-Ford from every unreached vertex).
//
//   channel  ports                                     handshake
//   edge in  edge_from edge_to edge_weight edge_valid  start & !busy
//            last_edge
//   result   has_negative_cycle                        done, one cycle
//   config   vertex_count                              cfg_valid & cfg_ready
//
// Edges load at one item per cycle while busy is low. The last_edge item starts
// the check, which holds busy through the counting sort, distance init, the
// Bellman-Ford passes of each search root and the per-vertex edge test; every
// step is one access pair on the edge and distance memories. The result strobe
// cannot be stalled. Reset clears the edge count and sets vertex_count to 1;
// memories need no clearing.
// ----------------------------------------------------------------------------
module negative_cycle_detector #(
  parameter int MAX_VERTICES = 1024,
  parameter int MAX_EDGES    = 4096,
  parameter int WEIGHT_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [ncd_pkg::VERTEX_BITS-1:0] edge_from,
  input  logic [ncd_pkg::VERTEX_BITS-1:0] edge_to,
  input  logic signed [15:0]              edge_weight,
  input  logic                            edge_valid,
  input  logic                            last_edge,
  output logic                            done,
  output logic                            has_negative_cycle,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ncd_pkg::NV_BITS-1:0]     vertex_count
);

  import ncd_pkg::*;

  ncd_status_t        status;
  logic [NV_BITS-1:0] nv_reg;
  logic [NV_BITS-1:0] nv;

  assign cfg_ready = !status.busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      nv_reg <= NV_BITS'(1);
    end else if (cfg_valid && cfg_ready) begin
      nv_reg <= vertex_count;
    end
  end

  // vertex count above the table size is clamped
  assign nv = (32'(nv_reg) > MAX_VERTICES) ? NV_BITS'(MAX_VERTICES) : nv_reg;

  ncd_engine #(
    .MAX_VERTICES (MAX_VERTICES),
    .MAX_EDGES    (MAX_EDGES),
    .WEIGHT_BITS  (WEIGHT_BITS)
  ) u_engine (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .edge_from   (edge_from),
    .edge_to     (edge_to),
    .edge_weight (edge_weight),
    .edge_valid  (edge_valid),
    .last_edge   (last_edge),
    .nv          (nv),
    .status      (status)
  );

  assign busy               = status.busy;
  assign done               = status.done;
  assign has_negative_cycle = status.result;

endmodule

[tb/negative_cycle_detector_tb.sv]
// ----------------------------------------------------------------------------
// negative_cycle_detector_tb
// Loads weighted edge lists into the detector and checks each verdict against
// an in-bench Bellman-Ford predictor or a fixed verdict: a directed table of
// corner cases first (empty graphs, extreme weights, out-of-range vertices,
// distance underflow, clamped vertex counts), then random graphs, with random
// gaps on the item side and vertex_count rewritten between graphs.
// ----------------------------------------------------------------------------
module negative_cycle_detector_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int EDGE_SLOTS     = 4096;
  localparam int VERTEX_SLOTS   = 1024;
  localparam int UNREACHED      = ncd_pkg::DIST_INF;
  localparam longint DIST_CEIL  = ncd_pkg::DIST_TOP;
  localparam longint DIST_FLOOR = -64'sd2147483648;
  localparam int TIMEOUT_CYCLES = 4000000;
  localparam int RANDOM_ITEMS   = 490;
  localparam int SETTLE_CYCLES  = 8;
  // row codes: no register write before the row, verdict taken from predictor
  localparam int KEEP_CFG = -1;
  localparam int PREDICT  = -1;

  typedef enum int {G_MIXED, G_CYCLE, G_OUTSIDE, G_TINY, G_HUGE} graph_kind_t;

  typedef struct {
    int          cfg;
    int          rep;
    logic [9:0]  src;
    logic [9:0]  dst;
    logic [15:0] wt;
    bit          valid;
    bit          last;
    int          want;
  } stim_row_t;

  logic                            clk = 1'b0;
  logic                            rst = 1'b1;
  logic                            start = 1'b0;
  logic [ncd_pkg::VERTEX_BITS-1:0] edge_from = '0;
  logic [ncd_pkg::VERTEX_BITS-1:0] edge_to = '0;
  logic signed [15:0]              edge_weight = '0;
  logic                            edge_valid = 1'b0;
  logic                            last_edge = 1'b0;
  logic                            cfg_valid = 1'b0;
  logic [ncd_pkg::NV_BITS-1:0]     vertex_count = 11'd1;
  logic                            busy;
  logic                            done;
  logic                            has_negative_cycle;
  logic                            cfg_ready;

  // predictor state
  int unsigned edge_src [EDGE_SLOTS];
  int unsigned edge_dst [EDGE_SLOTS];
  int          edge_wt  [EDGE_SLOTS];
  int unsigned stored_edges = 0;
  int unsigned nodes_cfg = 1;
  int unsigned grp_start [VERTEX_SLOTS+1];
  int unsigned grp_fill  [VERTEX_SLOTS];
  int unsigned edge_order [EDGE_SLOTS];
  int          reach_cost [VERTEX_SLOTS];

  bit          verdict_q [$];
  bit          oldest_verdict;
  stim_row_t   stim_rows [$];
  int          errors = 0;
  int          random_items = 0;
  longint      cycle_count = 0;
  bit          no_gaps = 1'b0;
  graph_kind_t cur_kind = G_MIXED;
  int unsigned cur_nv = 1;
  bit          kind_chosen = 1'b0;

  negative_cycle_detector DUT (
    .clk                (clk),
    .rst                (rst),
    .start              (start),
    .busy               (busy),
    .edge_from          (edge_from),
    .edge_to            (edge_to),
    .edge_weight        (edge_weight),
    .edge_valid         (edge_valid),
    .last_edge          (last_edge),
    .done               (done),
    .has_negative_cycle (has_negative_cycle),
    .cfg_valid          (cfg_valid),
    .cfg_ready          (cfg_ready),
    .vertex_count       (vertex_count)
  );

  always #4 clk = ~clk;

  // bellman-ford from every unreached root, edges grouped by source vertex
  function automatic bit graph_has_neg_cycle();
    int unsigned nv, cnt, e, i, k, u, p;
    longint s;
    nv = (nodes_cfg > VERTEX_SLOTS) ? VERTEX_SLOTS : nodes_cfg;
    if (nv == 0) return 1'b0;
    for (i = 0; i <= nv; i++) grp_start[i] = 0;
    for (k = 0; k < stored_edges; k++) begin
      if (edge_src[k] < nv && edge_dst[k] < nv) grp_start[edge_src[k] + 1]++;
    end
    for (i = 0; i < nv; i++) begin
      grp_start[i + 1] += grp_start[i];
      grp_fill[i] = grp_start[i];
    end
    for (k = 0; k < stored_edges; k++) begin
      if (edge_src[k] < nv && edge_dst[k] < nv) begin
        edge_order[grp_fill[edge_src[k]]] = k;
        grp_fill[edge_src[k]]++;
      end
    end
    cnt = grp_start[nv];
    for (i = 0; i < nv; i++) reach_cost[i] = UNREACHED;
    for (u = 0; u < nv; u++) begin
      if (reach_cost[u] == UNREACHED) begin
        reach_cost[u] = 0;
        for (p = 0; p < nv; p++) begin
          for (k = 0; k < cnt; k++) begin
            e = edge_order[k];
            if (reach_cost[edge_src[e]] == UNREACHED) continue;
            s = longint'(reach_cost[edge_src[e]]) + longint'(edge_wt[e]);
            // walk lighter than any simple path
            if (s < DIST_FLOOR) return 1'b1;
            if (s > DIST_CEIL) s = DIST_CEIL;
            if (longint'(reach_cost[edge_dst[e]]) > s) reach_cost[edge_dst[e]] = int'(s);
          end
        end
      end
      for (k = grp_start[u]; k < grp_start[u + 1]; k++) begin
        e = edge_order[k];
        s = longint'(reach_cost[u]) + longint'(edge_wt[e]);
        if (reach_cost[edge_dst[e]] == UNREACHED || longint'(reach_cost[edge_dst[e]]) > s)
          return 1'b1;
      end
    end
    return 1'b0;
  endfunction

  function automatic void accept_item(input logic [9:0] src, input logic [9:0] dst,
                                      input logic [15:0] wt, input bit valid,
                                      input bit last, input int want);
    if (valid && stored_edges < EDGE_SLOTS) begin
      edge_src[stored_edges] = src;
      edge_dst[stored_edges] = dst;
      edge_wt[stored_edges]  = int'($signed(wt));
      stored_edges++;
    end
    if (last) begin
      if (want == PREDICT) verdict_q = {verdict_q, graph_has_neg_cycle()};
      else verdict_q = {verdict_q, want[0]};
      stored_edges = 0;
    end
  endfunction

  function automatic stim_row_t edge_row(input logic [9:0] src, input logic [9:0] dst,
                                         input logic [15:0] wt, input bit valid,
                                         input bit last);
    stim_row_t r;
    r = '{KEEP_CFG, 1, src, dst, wt, valid, last, PREDICT};
    return r;
  endfunction

  function automatic void add_row(input stim_row_t row);
    stim_rows = {stim_rows, row};
  endfunction

  function automatic logic [9:0] rand_vertex(input int unsigned nv);
    if (nv == 0 || $urandom_range(0, 9) == 0) return 10'($urandom_range(0, 1023));
    return 10'($urandom_range(0, nv - 1));
  endfunction

  function automatic logic [15:0] rand_weight();
    if ($urandom_range(0, 99) < 15) return 16'($urandom());
    return 16'($urandom_range(0, 50) - 15);
  endfunction

  task automatic send_item(input logic [9:0] src, input logic [9:0] dst,
                           input logic [15:0] wt, input bit valid, input bit last,
                           input int want);
    int gap;
    gap = (no_gaps || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(0, 12);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start       <= 1'b1;
    edge_from   <= src;
    edge_to     <= dst;
    edge_weight <= wt;
    edge_valid  <= valid;
    last_edge   <= last;
    @(posedge clk);
    while (busy) @(posedge clk);
    accept_item(src, dst, wt, valid, last, want);
  endtask

  // wait for every pending verdict, then let the loader go quiet
  task automatic settle();
    start <= 1'b0;
    while (verdict_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_vertex_count(input logic [10:0] v);
    settle();
    cfg_valid    <= 1'b1;
    vertex_count <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    nodes_cfg = v;
  endtask

  task automatic random_graph();
    stim_row_t   plan [$];
    logic [9:0]  walk [$];
    logic [9:0]  src;
    logic [15:0] w;
    int          pick, ne, len, sum, target, i;
    if (!kind_chosen || $urandom_range(0, 9) < 4) begin
      kind_chosen = 1'b1;
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        cur_kind = G_MIXED;
        cur_nv   = $urandom_range(2, 8);
      end else if (pick < 75) begin
        cur_kind = G_CYCLE;
        cur_nv   = $urandom_range(2, 8);
      end else if (pick < 85) begin
        cur_kind = G_OUTSIDE;
        cur_nv   = $urandom_range(512, 1023);
      end else if (pick < 93) begin
        cur_kind = G_TINY;
        cur_nv   = $urandom_range(0, 1);
      end else begin
        cur_kind = G_HUGE;
        case ($urandom_range(0, 2))
          0: cur_nv = 1024;
          1: cur_nv = 2047;
          default: cur_nv = $urandom_range(1024, 2047);
        endcase
      end
      write_vertex_count(11'(cur_nv));
    end
    no_gaps = ($urandom_range(0, 4) == 0);

    case (cur_kind)
      G_CYCLE: begin
        // closed walk whose total weight sits at -1, 0 or +1, plus clutter
        len = $urandom_range(1, cur_nv);
        for (i = 0; i < len; i++) walk = {walk, 10'($urandom_range(0, cur_nv - 1))};
        ne = $urandom_range(0, 4);
        for (i = 0; i < ne; i++)
          plan = {plan, edge_row(rand_vertex(cur_nv), rand_vertex(cur_nv),
                                 rand_weight(), 1'b1, 1'b0)};
        sum    = 0;
        target = int'($urandom_range(0, 2)) - 1;
        for (i = 0; i < len; i++) begin
          if (i == len - 1) begin
            w = 16'(target - sum);
          end else begin
            w = 16'($urandom_range(0, 40) - 20);
            sum += int'($signed(w));
          end
          plan = {plan, edge_row(walk[i], walk[(i + 1) % len], w, 1'b1, 1'b0)};
        end
        plan[$].last = 1'b1;
      end
      G_OUTSIDE: begin
        // large vertex count, every edge touches a vertex beyond it
        ne = $urandom_range(1, 4);
        for (i = 0; i < ne; i++) begin
          src = 10'($urandom_range(0, 1023));
          plan = {plan, edge_row(src, (src < cur_nv) ? 10'($urandom_range(cur_nv, 1023))
                                                     : 10'($urandom_range(0, 1023)),
                                 16'($urandom()), 1'b1, 1'b0)};
        end
        if ($urandom_range(0, 1) == 0)
          plan = {plan, edge_row(10'($urandom()), 10'($urandom()), 16'($urandom()),
                                 1'b0, 1'b1)};
        else plan[$].last = 1'b1;
      end
      G_HUGE: begin
        plan = {plan, edge_row(10'($urandom()), 10'($urandom()), 16'($urandom()),
                               1'b0, 1'b1)};
      end
      default: begin
        ne = $urandom_range(1, 10);
        for (i = 0; i < ne; i++) begin
          if ($urandom_range(0, 9) == 0)
            plan = {plan, edge_row(10'($urandom()), 10'($urandom()), 16'($urandom()),
                                   1'b0, 1'b0)};
          plan = {plan, edge_row(rand_vertex(cur_nv), rand_vertex(cur_nv),
                                 rand_weight(), 1'b1, 1'b0)};
        end
        if ($urandom_range(0, 4) == 0)
          plan = {plan, edge_row(10'($urandom()), 10'($urandom()), 16'($urandom()),
                                 1'b0, 1'b1)};
        else plan[$].last = 1'b1;
      end
    endcase

    foreach (plan[i]) begin
      send_item(plan[i].src, plan[i].dst, plan[i].wt, plan[i].valid, plan[i].last,
                plan[i].want);
      if (plan[i].valid || plan[i].last) random_items++;
    end
  endtask

  always @(posedge clk) begin
    if (!rst && done === 1'b1) begin
      if (verdict_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got has_negative_cycle=%b",
                 $time, has_negative_cycle);
      end else begin
        oldest_verdict = verdict_q.pop_front();
        if (has_negative_cycle !== oldest_verdict) begin
          errors++;
          $display("%0t: has_negative_cycle mismatch, expected %b, got %b",
                   $time, oldest_verdict, has_negative_cycle);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > TIMEOUT_CYCLES) begin
      $display("** negative_cycle_detector: FAILED **");
      $finish;
    end
  end

  initial begin
    // vertex_count after reset is 1, empty graph
    add_row('{KEEP_CFG, 1, 10'd0, 10'd0, 16'h0000, 1'b0, 1'b1, 0});
    // zero vertices: nothing to check
    add_row('{0, 1, 10'd0, 10'd0, 16'hfffb, 1'b1, 1'b1, 0});
    // single vertex, zero then negative self loop
    add_row('{1, 1, 10'd0, 10'd0, 16'h0000, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd0, 10'd0, 16'hffff, 1'b1, 1'b1, 1});
    // two-vertex cycles at the weight extremes, total 0 then -1
    add_row('{2, 1, 10'd0, 10'd1, 16'h7fff, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd1, 10'd0, 16'h8001, 1'b1, 1'b1, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd0, 10'd1, 16'h7fff, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd1, 10'd0, 16'h8000, 1'b1, 1'b1, 1});
    // out-of-range endpoints are skipped, plus an item with no edge
    add_row('{3, 1, 10'h3ff, 10'h3ff, 16'h8000, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'h3ff, 10'h3ff, 16'h5a5a, 1'b0, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd5, 10'd0, 16'hffff, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd0, 10'h200, 16'h8000, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd0, 10'd0, 16'h0000, 1'b0, 1'b1, 0});
    // non-negative cycle through three vertices
    add_row('{4, 1, 10'd0, 10'd1, 16'd3, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd1, 10'd2, 16'hfffe, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd2, 10'd3, 16'd4, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd3, 10'd1, 16'hffff, 1'b1, 1'b1, PREDICT});
    // negative cycle only reachable from a later root
    add_row('{KEEP_CFG, 1, 10'd3, 10'd2, 16'hfffa, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd2, 10'd3, 16'd4, 1'b1, 1'b1, PREDICT});
    // largest vertex count, and a count that clamps to it
    add_row('{1024, 1, 10'd0, 10'd0, 16'h8000, 1'b1, 1'b1, 1});
    add_row('{2047, 1, 10'd0, 10'd0, 16'h0000, 1'b0, 1'b1, 0});
    // many heavy self loops over all passes drive the distance below the floor
    add_row('{1024, 65, 10'd0, 10'd0, 16'h8000, 1'b1, 1'b0, PREDICT});
    add_row('{KEEP_CFG, 1, 10'd0, 10'd0, 16'h0000, 1'b0, 1'b1, 1});

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (stim_rows[r]) begin
      if (stim_rows[r].cfg != KEEP_CFG) write_vertex_count(11'(stim_rows[r].cfg));
      repeat (stim_rows[r].rep)
        send_item(stim_rows[r].src, stim_rows[r].dst, stim_rows[r].wt,
                  stim_rows[r].valid, stim_rows[r].last, stim_rows[r].want);
    end

    while (random_items < RANDOM_ITEMS) random_graph();

    settle();
    if (errors == 0) begin
      $display("** negative_cycle_detector: PASSED **");
    end else begin
      $display("** negative_cycle_detector: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
sv/ncd_pkg.sv
sv/ncd_edge_ram.sv
sv/ncd_dist_ram.sv
sv/ncd_engine.sv
sv/negative_cycle_detector.sv
tb/negative_cycle_detector_tb.sv
